// ===== design/vsem_pkg.sv =====
// vsem_pkg: shared types and constants of the volume scaler / envelope meter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package vsem_pkg;

   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int LEVEL_W  = 8;

   // Q15 gain, reset value and the point from which samples pass unscaled
   localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd27853;
   localparam logic [GAIN_W-1:0] GAIN_BYPASS = 16'd32736;

   // default envelope mapping range
   localparam int NOISE_FLOOR_DEF = 100;
   localparam int LOUD_LEVEL_DEF  = 14000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       frame_end;
   } vsem_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       level_valid;
      logic [LEVEL_W-1:0]         mouth_level;
   } vsem_rsp_type;

   // handed from the scaling stage to the level mapping pipeline
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] y;
      logic                       last;
      logic [SAMPLE_W-1:0]        env;
   } vsem_mid_type;

endpackage

// ===== design/vsem_scale.sv =====
// vsem_scale: input register, Q15 gain scaling and frame peak / envelope state.
// Depends on vsem_pkg.
`timescale 1ns / 1ps

module vsem_scale import vsem_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vsem_req_type      req_payload,
   input  logic [GAIN_W-1:0] gain,
   output logic              mid_valid,
   input  logic              mid_ready,
   output vsem_mid_type      mid
);

   logic         in_valid_ff;
   vsem_req_type in_ff;
   logic         out_valid_ff;
   vsem_mid_type out_ff;
   logic [SAMPLE_W-1:0] peak_ff, peak_in;
   logic [SAMPLE_W-1:0] env_ff, env_in;

   logic         s1_ready, s0_ready, step;
   logic         neg;
   logic [SAMPLE_W-1:0] mag, q, y_mag;
   logic [2*SAMPLE_W-1:0] prod;
   logic [SAMPLE_W-1:0] peak_max;
   logic [19:0]  attack_sum, release_sum;
   logic [SAMPLE_W-1:0] env_next;
   vsem_mid_type out_in;

   // elastic two-register chain
   assign s1_ready  = !out_valid_ff || mid_ready;
   assign s0_ready  = !in_valid_ff || s1_ready;
   assign req_stall = !s0_ready;
   assign step      = in_valid_ff && s1_ready;

   // scaling: magnitude times gain, truncated toward zero; the quotient stays
   // below 32736 when not bypassed, so no clipping can occur
   always_comb begin
      neg   = in_ff.sample[SAMPLE_W-1];
      mag   = neg ? (SAMPLE_W'(0) - in_ff.sample) : in_ff.sample;
      prod  = mag * gain;
      q     = SAMPLE_W'(prod >> 15);
      y_mag = neg ? (SAMPLE_W'(0) - q) : q;
   end

   // peak tracking and envelope attack / release on the last sample of a frame
   always_comb begin
      peak_max    = (mag > peak_ff) ? mag : peak_ff;
      attack_sum  = 20'(env_ff) * 20'd3 + 20'(peak_max);
      release_sum = 20'(env_ff) * 20'd15 + 20'(peak_max);
      if (peak_max > env_ff) begin
         env_next = SAMPLE_W'(attack_sum >> 2);
      end else begin
         env_next = SAMPLE_W'(release_sum >> 4);
      end
      peak_in = peak_ff;
      env_in  = env_ff;
      if (step) begin
         if (in_ff.frame_end) begin
            peak_in = '0;
            env_in  = env_next;
         end else begin
            peak_in = peak_max;
         end
      end
      out_in.y    = (gain >= GAIN_BYPASS) ? in_ff.sample : $signed(y_mag);
      out_in.last = in_ff.frame_end;
      out_in.env  = env_next;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         peak_ff      <= '0;
         env_ff       <= '0;
      end else begin
         if (s0_ready) begin
            in_valid_ff <= req_valid;
         end
         if (s1_ready) begin
            out_valid_ff <= in_valid_ff;
         end
         peak_ff <= peak_in;
         env_ff  <= env_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s0_ready && req_valid) begin
         in_ff <= req_payload;
      end
      if (step) begin
         out_ff <= out_in;
      end
   end

   assign mid_valid = out_valid_ff;
   assign mid       = out_ff;

endmodule

// ===== design/vsem_level.sv =====
// vsem_level: maps the envelope onto 0..255 and holds the result register.
// Depends on vsem_pkg; division by the mapping span uses a reciprocal.
`timescale 1ns / 1ps

module vsem_level import vsem_pkg::*; #(
   parameter int NOISE_FLOOR = NOISE_FLOOR_DEF,
   parameter int LOUD_LEVEL  = LOUD_LEVEL_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         mid_valid,
   output logic         mid_ready,
   input  vsem_mid_type mid,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output vsem_rsp_type rsp_payload
);

   // elaboration-time reciprocal: RECIP = floor(2^SHIFT / SPAN) with
   // 2^SHIFT >= 256 * SPAN, so the estimate is at most one below the quotient
   localparam bit DEGEN  = (LOUD_LEVEL <= NOISE_FLOOR);
   localparam int SPAN   = DEGEN ? 1 : (LOUD_LEVEL - NOISE_FLOOR);
   localparam int SHIFT  = 8 + $clog2(SPAN);
   localparam int RECIP  = (2 ** SHIFT) / SPAN;
   localparam logic [15:0] SPAN_C  = 16'(SPAN);
   localparam logic [8:0]  RECIP_C = 9'(RECIP);
   localparam logic [16:0] FLOOR_C = 17'(NOISE_FLOOR);
   localparam logic [16:0] LOUD_C  = 17'(LOUD_LEVEL);

   logic s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s2_ready, s3_ready, s4_ready;

   logic signed [SAMPLE_W-1:0] s2_y_ff, s3_y_ff;
   logic s2_last_ff, s3_last_ff;
   logic s2_low_ff, s3_low_ff, s2_full_ff, s3_full_ff;
   logic [22:0] s2_n_ff, s3_n_ff;
   logic [31:0] s3_p_ff;
   vsem_rsp_type rsp_ff, rsp_in;

   logic [16:0] env_w;
   logic [14:0] d;
   logic [22:0] n_in;
   logic [7:0]  q0;
   logic [23:0] back_prod, rem;
   logic [LEVEL_W-1:0] lvl;

   assign s4_ready  = !s4_valid_ff || !rsp_stall;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign mid_ready = s2_ready;

   // offset above the noise floor times 255
   always_comb begin
      env_w = {1'b0, mid.env};
      d     = 15'(env_w - FLOOR_C);
      n_in  = {d, 8'b0} - {8'b0, d};
   end

   // quotient estimate, one-step correction and clamping
   always_comb begin
      q0        = 8'(s3_p_ff >> SHIFT);
      back_prod = 24'(q0) * 24'(SPAN_C);
      rem       = {1'b0, s3_n_ff} - back_prod;
      if (s3_low_ff) begin
         lvl = '0;
      end else if (s3_full_ff) begin
         lvl = '1;
      end else if (rem >= {8'b0, SPAN_C}) begin
         lvl = q0 + 8'd1;
      end else begin
         lvl = q0;
      end
      rsp_in.left_out    = s3_y_ff;
      rsp_in.right_out   = s3_y_ff;
      rsp_in.level_valid = s3_last_ff;
      rsp_in.mouth_level = s3_last_ff ? lvl : '0;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            s2_valid_ff <= mid_valid;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (s2_ready && mid_valid) begin
         s2_y_ff    <= mid.y;
         s2_last_ff <= mid.last;
         s2_low_ff  <= (env_w <= FLOOR_C);
         s2_full_ff <= DEGEN || (env_w >= LOUD_C);
         s2_n_ff    <= n_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_y_ff    <= s2_y_ff;
         s3_last_ff <= s2_last_ff;
         s3_low_ff  <= s2_low_ff;
         s3_full_ff <= s2_full_ff;
         s3_n_ff    <= s2_n_ff;
         s3_p_ff    <= 32'(s2_n_ff) * 32'(RECIP_C);
      end
      if (s4_ready && s3_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = s4_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/volume_scale_envelope_meter.sv =====
// Top level of the volume scaler with frame peak envelope meter.
// Depends on vsem_pkg, vsem_scale and vsem_level.
//
// Usage:
//   req_* carries one mono sample and its frame_end flag per transfer
//   (req_valid high and req_stall low at a rising edge). rsp_* returns one
//   result per sample: the scaled sample on left_out and right_out, and on a
//   frame end level_valid with the mapped envelope on mouth_level.
//   csr_write_en / csr_write_data load the Q15 volume gain; write only while
//   no sample is in flight.
//   Path: a result passes the five-register pipeline (input, scale,
//   offset, reciprocal multiply, result) before it is offered.
//   Throughput: one sample per cycle while rsp_stall is low.
//   Stall: rsp_stall holds the result register; the stages behind it keep
//   filling until each holds an item, then req_stall rises.
//   Reset: synchronous, clears all stage valids, the frame peak and the
//   envelope, and sets the gain to 27853.
`timescale 1ns / 1ps

module volume_scale_envelope_meter import vsem_pkg::*; #(
   parameter int NOISE_FLOOR = NOISE_FLOOR_DEF,
   parameter int LOUD_LEVEL  = LOUD_LEVEL_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vsem_req_type      req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vsem_rsp_type      rsp_payload,
   input  logic              csr_write_en,
   input  logic [GAIN_W-1:0] csr_write_data
);

   logic [GAIN_W-1:0] gain_ff;
   logic              mid_valid, mid_ready;
   vsem_mid_type      mid;

   // volume gain register
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_write_en) begin
         gain_ff <= csr_write_data;
      end
   end

   vsem_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .gain        (gain_ff),
      .mid_valid   (mid_valid),
      .mid_ready   (mid_ready),
      .mid         (mid)
   );

   vsem_level #(
      .NOISE_FLOOR (NOISE_FLOOR),
      .LOUD_LEVEL  (LOUD_LEVEL)
   ) u_level (
      .clock       (clock),
      .reset       (reset),
      .mid_valid   (mid_valid),
      .mid_ready   (mid_ready),
      .mid         (mid),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
